>>> design/ksel_pkg.sv
`default_nettype none
package ksel_pkg;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_QSTART,
      OP_RD_LO,
      OP_HIT_LO,
      OP_CAP_A,
      OP_CAP_M,
      OP_CAP_Z,
      OP_RD_PIV,
      OP_XW1,
      OP_XW2,
      OP_RD_J,
      OP_CMP,
      OP_PW1,
      OP_PW2,
      OP_RD_S,
      OP_FW1,
      OP_FW2,
      OP_PUSH
   } ksel_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHK,
      S_HIT,
      S_MA,
      S_MM,
      S_MZ,
      S_XRD,
      S_XW1,
      S_XW2,
      S_PRD,
      S_PCMP,
      S_PW1,
      S_PW2,
      S_FW1,
      S_FW2,
      S_DONE
   } ksel_state_type;

   typedef struct packed {
      logic qerr;
      logic lo_eq_hi;
      logic j_eq_hi;
      logic less;
      logic tgt_eq_s;
      logic out_free;
   } ksel_status_type;

endpackage
`default_nettype wire

>>> design/ksel_ram.sv
`default_nettype none
module ksel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> design/ksel_datapath.sv
`default_nettype none
module ksel_datapath import ksel_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ksel_op_type        op,
   input  wire logic               req_first,
   input  wire logic signed [31:0] req_value,
   input  wire logic [9:0]         req_rank,
   output ksel_status_type         status,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_element,
   output logic                    rsp_error
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = (CW > 10) ? CW : 10;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [AW-1:0] lo_ff, hi_ff, j_ff, s_ff, tgt_ff, piv_ff;
   logic signed [31:0] a_ff, m_ff, z_ff, pv_ff, vj_ff, res_ff;
   logic          err_ff;
   logic          rsp_valid_ff;
   logic signed [31:0] rsp_element_ff;
   logic          rsp_error_ff;

   logic          we;
   logic [AW-1:0] waddr, raddr, mid, piv_sel;
   logic signed [31:0] wdata, rdata;

   ksel_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      if (rdata < a_ff) begin
         if (a_ff < m_ff) piv_sel = lo_ff;
         else             piv_sel = (rdata < m_ff) ? mid : hi_ff;
      end else begin
         if (rdata < m_ff) piv_sel = hi_ff;
         else              piv_sel = (m_ff < a_ff) ? lo_ff : mid;
      end
   end

   always_comb begin
      status.qerr     = ovf_ff || (count_ff == '0) ||
                        (KW'(req_rank) >= KW'(count_ff));
      status.lo_eq_hi = (lo_ff == hi_ff);
      status.j_eq_hi  = (j_ff == hi_ff);
      status.less     = (rdata < pv_ff);
      status.tgt_eq_s = (tgt_ff == s_ff);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      we       = 1'b0;
      waddr    = s_ff;
      wdata    = pv_ff;
      raddr    = lo_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      case (op)
         OP_LOAD: begin
            if (req_first) begin
               we       = 1'b1;
               waddr    = '0;
               count_in = CW'(1);
               ovf_in   = 1'b0;
            end else if (count_ff < CW'(CAPACITY)) begin
               we       = 1'b1;
               waddr    = AW'(count_ff);
               count_in = count_ff + CW'(1);
            end else begin
               ovf_in = 1'b1;
            end
            wdata = req_value;
         end
         OP_CAP_A:  raddr = mid;
         OP_CAP_M:  raddr = hi_ff;
         OP_RD_PIV: raddr = piv_ff;
         OP_XW1: begin
            we    = 1'b1;
            waddr = piv_ff;
            wdata = z_ff;
         end
         OP_XW2: begin
            we    = 1'b1;
            waddr = hi_ff;
            wdata = pv_ff;
         end
         OP_RD_J:   raddr = j_ff;
         OP_CMP:    raddr = s_ff;
         OP_PW1: begin
            we    = 1'b1;
            waddr = s_ff;
            wdata = vj_ff;
         end
         OP_PW2: begin
            we    = 1'b1;
            waddr = j_ff;
            wdata = z_ff;
         end
         OP_RD_S:   raddr = s_ff;
         OP_FW1: begin
            we    = 1'b1;
            waddr = hi_ff;
            wdata = rdata;
         end
         OP_FW2: begin
            we    = 1'b1;
            waddr = s_ff;
            wdata = pv_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         if (op == OP_PUSH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_QSTART: begin
            tgt_ff <= AW'(req_rank);
            lo_ff  <= '0;
            hi_ff  <= AW'(count_ff - CW'(1));
            res_ff <= '0;
            err_ff <= 1'b1;
         end
         OP_HIT_LO: begin
            res_ff <= rdata;
            err_ff <= 1'b0;
         end
         OP_CAP_A:  a_ff <= rdata;
         OP_CAP_M:  m_ff <= rdata;
         OP_CAP_Z: begin
            z_ff   <= rdata;
            piv_ff <= piv_sel;
         end
         OP_XW1:    pv_ff <= rdata;
         OP_XW2: begin
            j_ff <= lo_ff;
            s_ff <= lo_ff;
         end
         OP_CMP: begin
            vj_ff <= rdata;
            if (!(rdata < pv_ff)) begin
               j_ff <= j_ff + AW'(1);
            end
         end
         OP_PW1:    z_ff <= rdata;
         OP_PW2: begin
            j_ff <= j_ff + AW'(1);
            s_ff <= s_ff + AW'(1);
         end
         OP_FW2: begin
            if (tgt_ff == s_ff) begin
               res_ff <= pv_ff;
               err_ff <= 1'b0;
            end else if (tgt_ff < s_ff) begin
               hi_ff <= s_ff - AW'(1);
            end else begin
               lo_ff <= s_ff + AW'(1);
            end
         end
         OP_PUSH: begin
            rsp_element_ff <= res_ff;
            rsp_error_ff   <= err_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_element = rsp_element_ff;
   assign rsp_error   = rsp_error_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("element count above capacity");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_PUSH) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result pushed over a waiting result");
   a_store_le_scan: assert property (@(posedge clock) disable iff (reset)
      (op == OP_PW2) |=> (s_ff <= j_ff)) else $error("store index passed scan index");

endmodule
`default_nettype wire

>>> design/ksel_ctrl.sv
`default_nettype none
module ksel_ctrl import ksel_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_func,
   input  wire ksel_status_type status,
   output ksel_op_type          op
);

   ksel_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!req_func) begin
                  op = OP_LOAD;
               end else begin
                  op       = OP_QSTART;
                  state_in = status.qerr ? S_DONE : S_CHK;
               end
            end
         end
         S_CHK: begin
            op       = OP_RD_LO;
            state_in = status.lo_eq_hi ? S_HIT : S_MA;
         end
         S_HIT: begin
            op       = OP_HIT_LO;
            state_in = S_DONE;
         end
         S_MA: begin
            op       = OP_CAP_A;
            state_in = S_MM;
         end
         S_MM: begin
            op       = OP_CAP_M;
            state_in = S_MZ;
         end
         S_MZ: begin
            op       = OP_CAP_Z;
            state_in = S_XRD;
         end
         S_XRD: begin
            op       = OP_RD_PIV;
            state_in = S_XW1;
         end
         S_XW1: begin
            op       = OP_XW1;
            state_in = S_XW2;
         end
         S_XW2: begin
            op       = OP_XW2;
            state_in = S_PRD;
         end
         S_PRD: begin
            if (status.j_eq_hi) begin
               op       = OP_RD_S;
               state_in = S_FW1;
            end else begin
               op       = OP_RD_J;
               state_in = S_PCMP;
            end
         end
         S_PCMP: begin
            op       = OP_CMP;
            state_in = status.less ? S_PW1 : S_PRD;
         end
         S_PW1: begin
            op       = OP_PW1;
            state_in = S_PW2;
         end
         S_PW2: begin
            op       = OP_PW2;
            state_in = S_PRD;
         end
         S_FW1: begin
            op       = OP_FW1;
            state_in = S_FW2;
         end
         S_FW2: begin
            op       = OP_FW2;
            state_in = status.tgt_eq_s ? S_DONE : S_CHK;
         end
         S_DONE: begin
            if (status.out_free) begin
               op       = OP_PUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> design/kth_smallest_select_unit.sv
// Order-statistic selection unit.
// The request channel carries loads (func 0) and queries (func 1). A load
// appends value to the element store, and the unit is ready again in the
// next cycle; first set on a load starts a new list. Loads beyond
// CAPACITY are dropped and mark the list as overflowed.
// A query returns on the response channel the element of zero-based rank
// rank, by quickselect with a median-of-three pivot and Lomuto partitioning
// over the single store memory. The store is reordered in place.
// A query that is out of range, on an empty or overflowed list, answers
// with error set and element zero, without a partition pass.
// Otherwise each partition pass reads the first, middle and last elements
// of the range, moves the median-of-three pivot to the last index, scans
// the range with a swap for each element below the pivot, and moves the
// pivot to its final index; the store has one read and one write port.
// The response is held in an output register until taken; while the
// receiver stalls, further loads are still accepted, but a later query
// waits for the register to free. Reset empties the list and clears any
// pending response; the store contents are not cleared.
`default_nettype none
module kth_smallest_select_unit import ksel_pkg::*; #(
   parameter int CAPACITY = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_func,
   input  wire logic               req_first,
   input  wire logic signed [31:0] req_value,
   input  wire logic [9:0]         req_rank,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_element,
   output logic                    rsp_error
);

   ksel_op_type     op;
   ksel_status_type status;

   ksel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .op        (op)
   );

   ksel_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .req_first   (req_first),
      .req_value   (req_value),
      .req_rank    (req_rank),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_element (rsp_element),
      .rsp_error   (rsp_error)
   );

endmodule
`default_nettype wire

>>> tb/kth_smallest_select_unit_test.sv
`timescale 1ns / 100ps
module kth_smallest_select_unit_test;
   import ksel_pkg::*;

   localparam int CAPACITY = 1024;
   localparam bit FUNC_LOAD = 1'b0;
   localparam bit FUNC_QUERY = 1'b1;

   class rank_scoreboard;
      int   elements[CAPACITY];
      int   element_count;
      bit   overflow_seen;
      int   expected_element[$];
      bit   expected_error[$];
      int   failures;

      function void note_request(bit func, bit first, int value, int rank);
         int sorted[$];
         int i;
         int j;
         int t;
         if (func == FUNC_LOAD) begin
            if (first) begin
               element_count = 0;
               overflow_seen = 0;
            end
            if (element_count < CAPACITY) begin
               elements[element_count] = value;
               element_count++;
            end else begin
               overflow_seen = 1;
            end
         end else if (overflow_seen || element_count == 0 || rank >= element_count) begin
            expected_element.push_back(0);
            expected_error.push_back(1'b1);
         end else begin
            for (i = 0; i < element_count; i++) sorted.push_back(elements[i]);
            for (i = 1; i < element_count; i++) begin
               t = sorted[i];
               j = i - 1;
               while (j >= 0 && sorted[j] > t) begin
                  sorted[j + 1] = sorted[j];
                  j--;
               end
               sorted[j + 1] = t;
            end
            expected_element.push_back(sorted[rank]);
            expected_error.push_back(1'b0);
         end
      endfunction

      function void check_response(int element, bit error);
         int e_el;
         bit e_err;
         if (expected_element.size() == 0) begin
            $display("%0t: unexpected response element %0d error %0b", $time, element, error);
            failures++;
            return;
         end
         e_el = expected_element.pop_front();
         e_err = expected_error.pop_front();
         if (element !== e_el) begin
            $display("%0t: element expected %0d actual %0d", $time, e_el, element);
            failures++;
         end
         if (error !== e_err) begin
            $display("%0t: error expected %0b actual %0b", $time, e_err, error);
            failures++;
         end
      endfunction

      function int pending();
         return expected_element.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic req_func;
   logic req_first;
   logic signed [31:0] req_value;
   logic [9:0] req_rank;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_element;
   logic rsp_error;

   rank_scoreboard sb = new();
   int burst_left = 0;
   int stall_mode = 0;

   kth_smallest_select_unit #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_func(req_func),
      .req_first(req_first), .req_value(req_value), .req_rank(req_rank),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_element(rsp_element), .rsp_error(rsp_error)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_element, rsp_error);
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send(bit func, bit first, int value, int rank);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= func;
      req_first <= first;
      req_value <= value;
      req_rank <= rank;
      do @(posedge clock); while (!req_ready);
      sb.note_request(func, first, value, rank & 32'h3ff);
   endtask

   task automatic load_list(int n, bit narrow);
      int i;
      for (i = 0; i < n; i++)
         send(FUNC_LOAD, i == 0, narrow ? $urandom_range(0, 15) - 8 : $urandom,
              $urandom);
   endtask

   initial begin
      int i;
      int n;
      int q;
      int items;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = 1'b0;
      req_first = 1'b0;
      req_value = '0;
      req_rank = '0;
      rsp_ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(FUNC_QUERY, 1'b0, 0, 0);
      send(FUNC_LOAD, 1'b1, 32'sh8000_0000, 0);
      send(FUNC_LOAD, 1'b0, 32'sh7fff_ffff, 0);
      send(FUNC_LOAD, 1'b0, 0, 0);
      send(FUNC_LOAD, 1'b0, -1, 0);
      send(FUNC_LOAD, 1'b0, -1, 0);
      for (i = 0; i < 6; i++) send(FUNC_QUERY, i[0], $urandom, i);
      send(FUNC_QUERY, 1'b0, 0, 1023);
      send(FUNC_LOAD, 1'b1, 5, 0);
      send(FUNC_QUERY, 1'b0, 0, 0);
      send(FUNC_QUERY, 1'b0, 0, 1);

      load_list(CAPACITY, 1'b0);
      send(FUNC_QUERY, 1'b0, 0, 1023);
      send(FUNC_QUERY, 1'b0, 0, 0);
      send(FUNC_QUERY, 1'b0, 0, 511);
      send(FUNC_LOAD, 1'b0, 3, 0);
      send(FUNC_QUERY, 1'b0, 0, 0);
      send(FUNC_LOAD, 1'b1, 7, 0);
      send(FUNC_QUERY, 1'b0, 0, 0);

      items = CAPACITY + 23;
      while (items < 1200) begin
         if ($urandom_range(0, 9) == 0) begin
            send($urandom_range(0, 1), $urandom_range(0, 1), $urandom, $urandom);
            items++;
         end else begin
            n = $urandom_range(1, 30);
            load_list(n, $urandom_range(0, 2) == 0);
            q = $urandom_range(1, 5);
            for (i = 0; i < q; i++)
               send(FUNC_QUERY, $urandom_range(0, 1), $urandom,
                    $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                                              : $urandom_range(0, n - 1));
            items += n + q;
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0) begin
         $display("kth_smallest_select_unit_test: PASS");
      end else begin
         $display("kth_smallest_select_unit_test: FAIL");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("kth_smallest_select_unit_test: FAIL");
      $finish;
   end

endmodule

>>> files.f
design/ksel_pkg.sv
design/ksel_ram.sv
design/ksel_datapath.sv
design/ksel_ctrl.sv
design/kth_smallest_select_unit.sv
tb/kth_smallest_select_unit_test.sv
